FILE: rtl/yce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package yce_pkg;

   typedef enum logic [2:0] {
      MODE_RED,
      MODE_GREEN,
      MODE_BLUE,
      MODE_U,
      MODE_V,
      MODE_U_DIV_V,
      MODE_V_DIV_U,
      MODE_RADIUS
   } mode_type;

   typedef enum logic {
      CSR_MODE,
      CSR_CONTRAST
   } csr_index_type;

   localparam logic [15:0] CONTRAST_RESET = 16'd256;
   localparam logic [7:0]  PIX_MAX        = 8'd255;

   localparam int unsigned CHROMA_SHIFT = 13;
   localparam int unsigned RECIP_SHIFT  = 16;

   localparam logic [14:0] DIV_RED_V   = 15'd7185;
   localparam logic [14:0] DIV_GREEN_U = 15'd20687;
   localparam logic [14:0] DIV_GREEN_V = 15'd14100;
   localparam logic [14:0] DIV_BLUE_U  = 15'd4037;

   localparam logic [17:0] RECIP_RED_V   = 18'((1 << (CHROMA_SHIFT + RECIP_SHIFT)) / 7185);
   localparam logic [17:0] RECIP_GREEN_U = 18'((1 << (CHROMA_SHIFT + RECIP_SHIFT)) / 20687);
   localparam logic [17:0] RECIP_GREEN_V = 18'((1 << (CHROMA_SHIFT + RECIP_SHIFT)) / 14100);
   localparam logic [17:0] RECIP_BLUE_U  = 18'((1 << (CHROMA_SHIFT + RECIP_SHIFT)) / 4037);

   function automatic logic [8:0] fix_quot(input logic [8:0] q0, input logic [7:0] mag,
                                           input logic [14:0] dvsr);
      logic [23:0] num;
      logic [23:0] prod;
      logic [23:0] rem;
      num  = 24'(mag) << CHROMA_SHIFT;
      prod = 24'(q0) * 24'(dvsr);
      rem  = num - prod;
      fix_quot = (rem >= 24'(dvsr)) ? q0 + 9'd1 : q0;
   endfunction

   function automatic logic [7:0] clamp_pix(input logic signed [11:0] x);
      if (x < 12'sd0) begin
         clamp_pix = 8'd0;
      end else if (x > 12'sd255) begin
         clamp_pix = PIX_MAX;
      end else begin
         clamp_pix = x[7:0];
      end
   endfunction

endpackage
`default_nettype wire

FILE: rtl/yce_linear.sv
`timescale 1ns / 1ps
`default_nettype none
module yce_linear import yce_pkg::*; (
   input  logic       clock,
   input  logic       enable,
   input  logic [7:0] luma,
   input  logic [7:0] chroma_u,
   input  logic [7:0] chroma_v,
   input  mode_type   mode,
   input  logic [15:0] contrast,
   output logic [7:0] pixel
);

   logic signed [8:0]  du;
   logic signed [8:0]  dv;
   logic [7:0]         mag_u;
   logic [7:0]         mag_v;
   logic signed [8:0]  view_d;
   logic signed [25:0] view_prod_in;
   logic [8:0]         qrv0_in, qgu0_in, qgv0_in, qbu0_in;

   logic [7:0]         luma1_ff;
   mode_type           mode1_ff;
   logic               neg_u1_ff, neg_v1_ff;
   logic [7:0]         mag_u1_ff, mag_v1_ff;
   logic [8:0]         qrv0_ff, qgu0_ff, qgv0_ff, qbu0_ff;
   logic signed [25:0] view_prod_ff;

   logic signed [26:0] view_n;
   logic [7:0]         view_in;

   logic [7:0]         luma2_ff;
   mode_type           mode2_ff;
   logic               neg_u2_ff, neg_v2_ff;
   logic [8:0]         qrv_ff, qgu_ff, qgv_ff, qbu_ff;
   logic [7:0]         view_ff;

   logic signed [11:0] t_red, t_gu, t_gv, t_blue, y_s;
   logic [7:0]         pix3_in;
   logic [7:0]         pix3_ff, pix4_ff, pix5_ff;

   always_comb begin
      du     = {~chroma_u[7], ~chroma_u[7], chroma_u[6:0]};
      dv     = {~chroma_v[7], ~chroma_v[7], chroma_v[6:0]};
      mag_u  = du[8] ? 8'(-du) : 8'(du);
      mag_v  = dv[8] ? 8'(-dv) : 8'(dv);
      view_d = (mode == MODE_V) ? dv : du;
      view_prod_in = 26'(view_d) * 26'($signed({1'b0, contrast}));
      qrv0_in = 9'((26'(mag_v) * 26'(RECIP_RED_V)) >> RECIP_SHIFT);
      qgu0_in = 9'((26'(mag_u) * 26'(RECIP_GREEN_U)) >> RECIP_SHIFT);
      qgv0_in = 9'((26'(mag_v) * 26'(RECIP_GREEN_V)) >> RECIP_SHIFT);
      qbu0_in = 9'((26'(mag_u) * 26'(RECIP_BLUE_U)) >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         luma1_ff     <= luma;
         mode1_ff     <= mode;
         neg_u1_ff    <= du[8];
         neg_v1_ff    <= dv[8];
         mag_u1_ff    <= mag_u;
         mag_v1_ff    <= mag_v;
         qrv0_ff      <= qrv0_in;
         qgu0_ff      <= qgu0_in;
         qgv0_ff      <= qgv0_in;
         qbu0_ff      <= qbu0_in;
         view_prod_ff <= view_prod_in;
      end
   end

   always_comb begin
      view_n = 27'(view_prod_ff) + 27'sd32768;
      if (view_n <= 27'sd0) begin
         view_in = 8'd0;
      end else if (view_n[25:16] != 10'd0) begin
         view_in = PIX_MAX;
      end else begin
         view_in = view_n[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         luma2_ff  <= luma1_ff;
         mode2_ff  <= mode1_ff;
         neg_u2_ff <= neg_u1_ff;
         neg_v2_ff <= neg_v1_ff;
         qrv_ff    <= fix_quot(qrv0_ff, mag_v1_ff, DIV_RED_V);
         qgu_ff    <= fix_quot(qgu0_ff, mag_u1_ff, DIV_GREEN_U);
         qgv_ff    <= fix_quot(qgv0_ff, mag_v1_ff, DIV_GREEN_V);
         qbu_ff    <= fix_quot(qbu0_ff, mag_u1_ff, DIV_BLUE_U);
         view_ff   <= view_in;
      end
   end

   always_comb begin
      y_s    = $signed({4'b0, luma2_ff});
      t_red  = neg_v2_ff ? -$signed({3'b0, qrv_ff}) : $signed({3'b0, qrv_ff});
      t_gu   = neg_u2_ff ? -$signed({3'b0, qgu_ff}) : $signed({3'b0, qgu_ff});
      t_gv   = neg_v2_ff ? -$signed({3'b0, qgv_ff}) : $signed({3'b0, qgv_ff});
      t_blue = neg_u2_ff ? -$signed({3'b0, qbu_ff}) : $signed({3'b0, qbu_ff});
      case (mode2_ff) inside
         MODE_RED:       pix3_in = clamp_pix(y_s + t_red);
         MODE_GREEN:     pix3_in = clamp_pix(y_s - (t_gu + t_gv));
         MODE_BLUE:      pix3_in = clamp_pix(y_s + t_blue);
         MODE_U, MODE_V: pix3_in = view_ff;
         default:        pix3_in = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pix3_ff <= pix3_in;
         pix4_ff <= pix3_ff;
         pix5_ff <= pix4_ff;
      end
   end

   assign pixel = pix5_ff;

endmodule
`default_nettype wire

FILE: rtl/yce_ratio.sv
`timescale 1ns / 1ps
`default_nettype none
module yce_ratio import yce_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [7:0]  chroma_u,
   input  logic [7:0]  chroma_v,
   input  mode_type    mode,
   input  logic [15:0] contrast,
   output logic [7:0]  pixel
);

   localparam int unsigned STEP_STAGES = 4;
   localparam int unsigned BITS_PER_STAGE = 2;

   logic [7:0]  num;
   logic [7:0]  den;
   logic [23:0] dividend_ff;
   logic [7:0]  den_ff;

   logic [23:0] rem_in   [STEP_STAGES];
   logic [7:0]  quot_in  [STEP_STAGES];
   logic [7:0]  den_in   [STEP_STAGES];
   logic        sat_in   [STEP_STAGES];
   logic [23:0] rem_ff   [STEP_STAGES];
   logic [7:0]  quot_ff  [STEP_STAGES];
   logic [7:0]  dpipe_ff [STEP_STAGES];
   logic        sat_ff   [STEP_STAGES];

   always_comb begin
      num = (mode == MODE_V_DIV_U) ? chroma_v : chroma_u;
      den = (mode == MODE_V_DIV_U) ? chroma_u : chroma_v;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dividend_ff <= 24'(contrast) * 24'(num);
         den_ff      <= den;
      end
   end

   // A quotient of 256 or more, and a zero divisor, both saturate.
   always_comb begin
      logic [23:0] rem_v;
      logic [7:0]  quot_v;
      logic [7:0]  den_v;
      logic        sat_v;
      for (int s = 0; s < STEP_STAGES; s++) begin
         if (s == 0) begin
            rem_v  = dividend_ff;
            quot_v = 8'd0;
            den_v  = den_ff;
            sat_v  = (dividend_ff[23:16] >= den_ff);
         end else begin
            rem_v  = rem_ff[s-1];
            quot_v = quot_ff[s-1];
            den_v  = dpipe_ff[s-1];
            sat_v  = sat_ff[s-1];
         end
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            if (rem_v >= (24'(den_v) << (15 - BITS_PER_STAGE * s - j))) begin
               rem_v = rem_v - (24'(den_v) << (15 - BITS_PER_STAGE * s - j));
               quot_v[7 - BITS_PER_STAGE * s - j] = 1'b1;
            end
         end
         rem_in[s]  = rem_v;
         quot_in[s] = quot_v;
         den_in[s]  = den_v;
         sat_in[s]  = sat_v;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < STEP_STAGES; s++) begin
            rem_ff[s]   <= rem_in[s];
            quot_ff[s]  <= quot_in[s];
            dpipe_ff[s] <= den_in[s];
            sat_ff[s]   <= sat_in[s];
         end
      end
   end

   assign pixel = sat_ff[STEP_STAGES-1] ? PIX_MAX : quot_ff[STEP_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/yce_radius.sv
`timescale 1ns / 1ps
`default_nettype none
module yce_radius import yce_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [7:0]  chroma_u,
   input  logic [7:0]  chroma_v,
   input  logic [15:0] contrast,
   output logic [7:0]  pixel
);

   localparam int unsigned STEP_STAGES = 3;
   localparam int unsigned STEPS_PER_STAGE = 3;

   logic signed [8:0]  du;
   logic signed [8:0]  dv;
   logic signed [17:0] sq_u;
   logic signed [17:0] sq_v;
   logic [17:0]        rad_in;

   logic [17:0] rad_ff;
   logic [15:0] cst_ff;

   logic [11:0] rem_in   [STEP_STAGES];
   logic [8:0]  root_in  [STEP_STAGES];
   logic [17:0] rad_p_in [STEP_STAGES];
   logic [15:0] cst_in   [STEP_STAGES];
   logic [11:0] rem_ff   [STEP_STAGES];
   logic [8:0]  root_ff  [STEP_STAGES];
   logic [17:0] rad_p_ff [STEP_STAGES];
   logic [15:0] cst_p_ff [STEP_STAGES];

   logic [24:0] scaled;
   logic [7:0]  pix_in;
   logic [7:0]  pix_ff;

   always_comb begin
      du     = {~chroma_u[7], ~chroma_u[7], chroma_u[6:0]};
      dv     = {~chroma_v[7], ~chroma_v[7], chroma_v[6:0]};
      sq_u   = du * du;
      sq_v   = dv * dv;
      rad_in = {(sq_u[15:0] + sq_v[15:0]), 2'b00};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff <= rad_in;
         cst_ff <= contrast;
      end
   end

   always_comb begin
      logic [11:0] rem_v;
      logic [8:0]  root_v;
      logic [17:0] rad_v;
      logic [15:0] cst_v;
      for (int s = 0; s < STEP_STAGES; s++) begin
         if (s == 0) begin
            rem_v  = 12'd0;
            root_v = 9'd0;
            rad_v  = rad_ff;
            cst_v  = cst_ff;
         end else begin
            rem_v  = rem_ff[s-1];
            root_v = root_ff[s-1];
            rad_v  = rad_p_ff[s-1];
            cst_v  = cst_p_ff[s-1];
         end
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            rem_v = {rem_v[9:0],
                     rad_v[2 * (8 - STEPS_PER_STAGE * s - j) +: 2]};
            if (rem_v >= {1'b0, root_v, 2'b01}) begin
               rem_v  = rem_v - {1'b0, root_v, 2'b01};
               root_v = {root_v[7:0], 1'b1};
            end else begin
               root_v = {root_v[7:0], 1'b0};
            end
         end
         rem_in[s]   = rem_v;
         root_in[s]  = root_v;
         rad_p_in[s] = rad_v;
         cst_in[s]   = cst_v;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < STEP_STAGES; s++) begin
            rem_ff[s]   <= rem_in[s];
            root_ff[s]  <= root_in[s];
            rad_p_ff[s] <= rad_p_in[s];
            cst_p_ff[s] <= cst_in[s];
         end
      end
   end

   always_comb begin
      scaled = 25'(cst_p_ff[STEP_STAGES-1]) * 25'(root_ff[STEP_STAGES-1]);
      pix_in = scaled[24] ? PIX_MAX : scaled[23:16];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pix_ff <= pix_in;
      end
   end

   assign pixel = pix_ff;

endmodule
`default_nettype wire

FILE: rtl/yuv_channel_extract_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel channel extractor for upsampled YUV video.
// The req channel takes one beat per pixel: luma and the chroma pair that covers it.
// The rsp channel returns one 8-bit pixel per request beat, in order.
// The csr port writes the mode register (index 0) and the 8.8 contrast register
// (index 1); write them only while no beat is in flight.
// Modes 0 to 2 rebuild red, green or blue; 3 and 4 give scaled U or V; 5 and 6
// give U/V or V/U times contrast; 7 gives the chroma radius times contrast.
// Throughput is one beat per cycle when the response is not stalled; the four
// ratio divider stages retire two quotient bits a cycle and the three square
// root stages retire three root bits.
// When the receiver stalls with a response held, the whole pipeline freezes and
// req_ready drops; nothing is lost or repeated.
// Reset clears all valid bits, sets mode to red and contrast to 1.0.
module yuv_channel_extract_unit import yce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_luma,
   input  logic [7:0]  req_chroma_u,
   input  logic [7:0]  req_chroma_v,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned STAGES = 6;

   mode_type    mode_ff;
   logic [15:0] contrast_ff;

   logic              advance;
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_pixel_ff;
   logic [7:0]        pixel_in;

   logic [7:0]  luma0_ff, chroma_u0_ff, chroma_v0_ff;
   logic [15:0] contrast0_ff;
   mode_type    mode_pipe_ff [STAGES];

   logic [7:0] lin_pixel, ratio_pixel, radius_pixel;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign vld_in    = {vld_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RED;
         contrast_ff  <= CONTRAST_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_MODE:     mode_ff     <= mode_type'(csr_wdata[2:0]);
               CSR_CONTRAST: contrast_ff <= csr_wdata;
               default:      mode_ff     <= mode_ff;
            endcase
         end
         if (advance) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         luma0_ff        <= req_luma;
         chroma_u0_ff    <= req_chroma_u;
         chroma_v0_ff    <= req_chroma_v;
         contrast0_ff    <= contrast_ff;
         mode_pipe_ff[0] <= mode_ff;
         for (int k = 1; k < STAGES; k++) begin
            mode_pipe_ff[k] <= mode_pipe_ff[k-1];
         end
         rsp_pixel_ff    <= pixel_in;
      end
   end

   yce_linear u_linear (
      .clock    (clock),
      .enable   (advance),
      .luma     (luma0_ff),
      .chroma_u (chroma_u0_ff),
      .chroma_v (chroma_v0_ff),
      .mode     (mode_pipe_ff[0]),
      .contrast (contrast0_ff),
      .pixel    (lin_pixel)
   );

   yce_ratio u_ratio (
      .clock    (clock),
      .enable   (advance),
      .chroma_u (chroma_u0_ff),
      .chroma_v (chroma_v0_ff),
      .mode     (mode_pipe_ff[0]),
      .contrast (contrast0_ff),
      .pixel    (ratio_pixel)
   );

   yce_radius u_radius (
      .clock    (clock),
      .enable   (advance),
      .chroma_u (chroma_u0_ff),
      .chroma_v (chroma_v0_ff),
      .contrast (contrast0_ff),
      .pixel    (radius_pixel)
   );

   always_comb begin
      case (mode_pipe_ff[STAGES-1]) inside
         MODE_RED, MODE_GREEN, MODE_BLUE, MODE_U, MODE_V: pixel_in = lin_pixel;
         MODE_U_DIV_V, MODE_V_DIV_U:                      pixel_in = ratio_pixel;
         default:                                         pixel_in = radius_pixel;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_valid_reaches_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid == $past(vld_ff[STAGES-1]))
      else $error("last stage valid bit not carried to the response");

   a_contrast_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && csr_index == CSR_CONTRAST |=> contrast_ff == $past(csr_wdata))
      else $error("contrast register write lost");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && csr_index == CSR_MODE |=> mode_ff == $past(csr_wdata[2:0]))
      else $error("mode register write lost");

endmodule
`default_nettype wire
